@@ hdl/pp_pkg.sv @@
// Shared constants, types and coefficient functions for the point projector.
package pp_pkg;

  localparam int POINT_BITS_DEF     = 18;
  localparam int COEF_FRAC_BITS_DEF = 16;

  localparam int PIX_W   = 12;
  localparam int RANGE_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int COLOR_W = 8;

  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_COLOR_RANGE  = 2'd2;

  localparam logic [PIX_W-1:0]   IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [PIX_W-1:0]   IMAGE_HEIGHT_RST = 12'd480;
  localparam logic [RANGE_W-1:0] COLOR_RANGE_RST  = 16'd10000;

  // Quotient bits of a pixel divide, plus one stage for the range check.
  localparam int QUO_W   = PIX_W;
  localparam int DIV_LAT = QUO_W + 1;

  // Colour numerator is 4 * 255 * f with f <= range.
  localparam int COLOR_NUM_W = 26;
  localparam int COLOR_SCALE = 1020;
  localparam int SEG_W       = 24;

  localparam longint SCALE_DEN = 64'd100000000000000;

  typedef enum logic [1:0] {
    SEG_BLUE_GREEN = 2'd0,
    SEG_GREEN_FADE = 2'd1,
    SEG_RED_RISE   = 2'd2,
    SEG_RED_GREEN  = 2'd3
  } seg_t;

  // Extrinsics in units of 1e-8.
  function automatic longint ext_e8(input int row, input int col);
    longint v;
    v = 0;
    case (row * 4 + col)
      0:  v = 99994800;
      1:  v = -368532;
      2:  v = 955344;
      3:  v = -3628590;
      4:  v = 250985;
      5:  v = 99274000;
      6:  v = 12025400;
      7:  v = -40832200;
      8:  v = -992725;
      9:  v = -12022400;
      10: v = 99269700;
      11: v = 4218810;
      default: v = 0;
    endcase
    return v;
  endfunction

  // Entry of K * T scaled to cf fraction bits, rounded half away from zero.
  function automatic longint pp_coef(input int row, input int col, input int cf);
    longint m;
    longint mag;
    longint acc;
    longint r;
    m = 0;
    case (row)
      0: m = 64'd620119409 * ext_e8(0, col) + 64'd329103454 * ext_e8(2, col);
      1: m = 64'd619245417 * ext_e8(1, col) + 64'd248727013 * ext_e8(2, col);
      default: m = 64'd1000000 * ext_e8(2, col);
    endcase
    mag = (m < 0) ? -m : m;
    acc = mag / SCALE_DEN;
    r   = mag % SCALE_DEN;
    for (int i = 0; i < 32; i++) begin
      if (i < cf) begin
        acc = acc << 1;
        r   = r << 1;
        if (r >= SCALE_DEN) begin
          acc = acc | 64'd1;
          r   = r - SCALE_DEN;
        end
      end
    end
    if (2 * r >= SCALE_DEN) acc = acc + 1;
    return (m < 0) ? -acc : acc;
  endfunction

  function automatic logic [COLOR_W-1:0] clamp8(input logic signed [13:0] v);
    logic [COLOR_W-1:0] res;
    if (v < 0) res = '0;
    else if (v > 14'sd255) res = '1;
    else res = v[COLOR_W-1:0];
    return res;
  endfunction

endpackage

@@ hdl/pp_project.sv @@
// Camera matrix multiply: products, sums and magnitudes over three stages.
module pp_project #(
  parameter int POINT_BITS     = pp_pkg::POINT_BITS_DEF,
  parameter int COEF_FRAC_BITS = pp_pkg::COEF_FRAC_BITS_DEF,
  localparam int ACC_W = (POINT_BITS + COEF_FRAC_BITS + 13 > 64) ? 64 :
                         POINT_BITS + COEF_FRAC_BITS + 13
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [POINT_BITS-1:0] fwd,
  input  logic signed [POINT_BITS-1:0] left,
  input  logic signed [POINT_BITS-1:0] up,
  output logic [ACC_W-1:0]             mag_u,
  output logic [ACC_W-1:0]             mag_v,
  output logic [ACC_W-1:0]             mag_w,
  output logic                         neg_u,
  output logic                         neg_v
);
  import pp_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 12;

  logic signed [ACC_W-1:0] dx [3];
  logic [ACC_W-1:0]        mag [3];
  logic                    neg [3];

  // Camera vector is (-left, -up, fwd, 1000).
  assign dx[0] = -ACC_W'(left);
  assign dx[1] = -ACC_W'(up);
  assign dx[2] = ACC_W'(fwd);

  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_row
      localparam logic signed [COEF_W-1:0] C0 = COEF_W'(pp_coef(i, 0, COEF_FRAC_BITS));
      localparam logic signed [COEF_W-1:0] C1 = COEF_W'(pp_coef(i, 1, COEF_FRAC_BITS));
      localparam logic signed [COEF_W-1:0] C2 = COEF_W'(pp_coef(i, 2, COEF_FRAC_BITS));
      localparam longint CK = pp_coef(i, 3, COEF_FRAC_BITS) * 1000;

      logic signed [ACC_W-1:0] c0x, c1x, c2x;
      logic signed [ACC_W-1:0] p0_r, p1_r, p2_r, sum_r;
      logic [ACC_W-1:0]        mag_r;
      logic                    neg_r;

      assign c0x = ACC_W'(C0);
      assign c1x = ACC_W'(C1);
      assign c2x = ACC_W'(C2);

      always_ff @(posedge clk) begin
        if (en) begin
          p0_r  <= c0x * dx[0];
          p1_r  <= c1x * dx[1];
          p2_r  <= c2x * dx[2];
          sum_r <= p0_r + p1_r + p2_r + ACC_W'(CK);
          neg_r <= sum_r[ACC_W-1];
          mag_r <= sum_r[ACC_W-1] ? ACC_W'(-sum_r) : ACC_W'(sum_r);
        end
      end

      assign mag[i] = mag_r;
      assign neg[i] = neg_r;
    end
  endgenerate

  assign mag_u = mag[0];
  assign mag_v = mag[1];
  assign mag_w = mag[2];
  assign neg_u = neg[0] ^ neg[2];
  assign neg_v = neg[1] ^ neg[2];

endmodule

@@ hdl/pp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with range flag.
module pp_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 16,
  localparam int CW = (NUM_W > DEN_W + pp_pkg::QUO_W) ? NUM_W : DEN_W + pp_pkg::QUO_W
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [NUM_W-1:0]         num,
  input  logic [DEN_W-1:0]         den,
  output logic [pp_pkg::QUO_W-1:0] quo,
  output logic                     rem_nz,
  output logic                     ovf
);
  import pp_pkg::*;

  logic [CW-1:0]    rem_r [DIV_LAT];
  logic [DEN_W-1:0] den_r [DIV_LAT];
  logic [QUO_W-1:0] q_r   [DIV_LAT];
  logic             ovf_r [DIV_LAT];

  // Flag quotients that do not fit; later bits are then don't-care.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= CW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= CW'(num) >= (CW'(den) << QUO_W);
    end
  end

  genvar s;
  generate
    for (s = 1; s < DIV_LAT; s++) begin : g_stage
      localparam int K = QUO_W - s;
      logic [CW-1:0] sh;
      logic          ge;

      assign sh = CW'(den_r[s-1]) << K;
      assign ge = rem_r[s-1] >= sh;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? rem_r[s-1] - sh : rem_r[s-1];
          q_r[s]   <= q_r[s-1] | (QUO_W'(ge) << K);
          den_r[s] <= den_r[s-1];
          ovf_r[s] <= ovf_r[s-1];
        end
      end
    end
  endgenerate

  assign quo    = q_r[DIV_LAT-1];
  assign rem_nz = |rem_r[DIV_LAT-1];
  assign ovf    = ovf_r[DIV_LAT-1];

endmodule

@@ hdl/pp_color.sv @@
// Four-segment blue-green-red distance colour from the scaled quotient.
module pp_color (
  input  pp_pkg::seg_t                 seg,
  input  logic [pp_pkg::QUO_W-1:0]     quo,
  input  logic                         rem_nz,
  output logic [pp_pkg::COLOR_W-1:0]   red,
  output logic [pp_pkg::COLOR_W-1:0]   green,
  output logic [pp_pkg::COLOR_W-1:0]   blue
);
  import pp_pkg::*;

  localparam logic signed [13:0] FADE_TOP = 14'sd511;
  localparam logic signed [13:0] RISE_OFF = 14'sd508;
  localparam logic signed [13:0] DROP_TOP = 14'sd1023;

  logic signed [13:0] fl, cl;

  // Floor and ceiling of 4n.
  assign fl = $signed(14'(quo));
  assign cl = fl + $signed(14'(rem_nz));

  always_comb begin
    red   = '0;
    green = '0;
    blue  = '0;
    case (seg)
      SEG_BLUE_GREEN: begin
        green = clamp8(fl);
        blue  = '1;
      end
      SEG_GREEN_FADE: begin
        green = '1;
        blue  = clamp8(FADE_TOP - cl);
      end
      SEG_RED_RISE: begin
        red   = clamp8(fl - RISE_OFF);
        green = '1;
      end
      SEG_RED_GREEN: begin
        red   = '1;
        green = clamp8(DROP_TOP - cl);
      end
      default: begin
        red = '0;
      end
    endcase
  end

endmodule

@@ hdl/lidar_point_to_pixel_projector.sv @@
// Lidar point projector: one point per cycle in, pixel position and colour out.
// Each accepted point yields one result after an input register, three stages of
// matrix multiply (products, sums, magnitudes), 13 stages of pipelined restoring
// division shared in form by column, row and colour, and an output register. A
// new point is taken every cycle while the result side keeps up; while one waits,
// in_ready follows out_ready; all stages hold while it is low. The user must
// see that configuration is taken between points; the block does not enforce it.
module lidar_point_to_pixel_projector #(
  parameter int POINT_BITS     = pp_pkg::POINT_BITS_DEF,
  parameter int COEF_FRAC_BITS = pp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [POINT_BITS-1:0]   in_point_fwd_mm,
  input  logic signed [POINT_BITS-1:0]   in_point_left_mm,
  input  logic signed [POINT_BITS-1:0]   in_point_up_mm,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic                           out_in_front,
  output logic [pp_pkg::PIX_W-1:0]       out_pixel_col,
  output logic [pp_pkg::PIX_W-1:0]       out_pixel_row,
  output logic [pp_pkg::COLOR_W-1:0]     out_red,
  output logic [pp_pkg::COLOR_W-1:0]     out_green,
  output logic [pp_pkg::COLOR_W-1:0]     out_blue,
  input  logic                           cfg_we,
  input  logic [pp_pkg::IDX_W-1:0]       cfg_index,
  input  logic [pp_pkg::CFG_W-1:0]       cfg_data
);
  import pp_pkg::*;

  localparam int ACC_W = (POINT_BITS + COEF_FRAC_BITS + 13 > 64) ? 64 :
                         POINT_BITS + COEF_FRAC_BITS + 13;
  localparam int MW = (POINT_BITS > RANGE_W + 1) ? POINT_BITS : RANGE_W + 1;

  logic en;

  logic [PIX_W-1:0]   width_r, height_r;
  logic [RANGE_W-1:0] range_r, range_eff;

  logic                         v_a_r, v_b_r, v_c_r, v_d_r;
  logic                         v_e_r [DIV_LAT];
  logic signed [POINT_BITS-1:0] fwd_a_r, left_a_r, up_a_r;
  logic                         front_a;
  logic [MW-1:0]                fz, rz;
  logic [RANGE_W-1:0]           f_nxt;

  logic [RANGE_W-1:0]     f_b_r, r_b_r, r_c_r, r_d_r;
  logic                   front_b_r, front_c_r, front_d_r;
  logic [COLOR_NUM_W-1:0] x_c_r, x_d_r;
  logic [SEG_W-1:0]       n255, r63, r127, r191;
  seg_t                   seg_nxt, seg_c_r, seg_d_r;

  logic [ACC_W-1:0] mag_u, mag_v, mag_w;
  logic             neg_u, neg_v;

  logic front_e_r [DIV_LAT];
  seg_t seg_e_r   [DIV_LAT];
  logic nu_e_r    [DIV_LAT];
  logic nv_e_r    [DIV_LAT];

  logic [QUO_W-1:0] qu, qv, qc;
  logic             ovf_u, ovf_v, rnz_c;
  logic             hit;
  logic [COLOR_W-1:0] red_c, green_c, blue_c;

  logic                out_valid_r;
  logic                hit_r, front_r;
  logic [PIX_W-1:0]    col_r, row_r;
  logic [COLOR_W-1:0]  red_r, green_r, blue_r;

  // Hold every stage while a result waits and out_ready is low.
  assign en       = out_ready || !out_valid_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
      range_r  <= COLOR_RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[PIX_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[PIX_W-1:0];
        CFG_COLOR_RANGE:  range_r  <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign range_eff = (range_r == '0) ? RANGE_W'(1) : range_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      v_d_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) v_e_r[k] <= 1'b0;
    end else if (en) begin
      v_a_r    <= in_valid;
      v_b_r    <= v_a_r;
      v_c_r    <= v_b_r;
      v_d_r    <= v_c_r;
      v_e_r[0] <= v_d_r;
      for (int k = 1; k < DIV_LAT; k++) v_e_r[k] <= v_e_r[k-1];
      out_valid_r <= v_e_r[DIV_LAT-1];
    end
  end

  // Stage A: input register.
  always_ff @(posedge clk) begin
    if (en) begin
      fwd_a_r  <= in_point_fwd_mm;
      left_a_r <= in_point_left_mm;
      up_a_r   <= in_point_up_mm;
    end
  end

  assign front_a = !fwd_a_r[POINT_BITS-1] && (|fwd_a_r);
  assign fz      = MW'(fwd_a_r);
  assign rz      = MW'(range_eff);

  // Saturate distance at the colour range; zero for points not in front.
  always_comb begin
    f_nxt = '0;
    if (front_a) f_nxt = (fz > rz) ? range_eff : fz[RANGE_W-1:0];
  end

  assign n255 = SEG_W'(f_b_r) * SEG_W'(255);
  assign r63  = SEG_W'(r_b_r) * SEG_W'(63);
  assign r127 = SEG_W'(r_b_r) * SEG_W'(127);
  assign r191 = SEG_W'(r_b_r) * SEG_W'(191);

  always_comb begin
    if (n255 <= r63)       seg_nxt = SEG_BLUE_GREEN;
    else if (n255 <= r127) seg_nxt = SEG_GREEN_FADE;
    else if (n255 <= r191) seg_nxt = SEG_RED_RISE;
    else                   seg_nxt = SEG_RED_GREEN;
  end

  // Stages B to D of the colour path, aligned with the matrix multiply.
  always_ff @(posedge clk) begin
    if (en) begin
      f_b_r     <= f_nxt;
      r_b_r     <= range_eff;
      front_b_r <= front_a;
      x_c_r     <= COLOR_NUM_W'(f_b_r) * COLOR_NUM_W'(COLOR_SCALE);
      seg_c_r   <= seg_nxt;
      r_c_r     <= r_b_r;
      front_c_r <= front_b_r;
      x_d_r     <= x_c_r;
      seg_d_r   <= seg_c_r;
      r_d_r     <= r_c_r;
      front_d_r <= front_c_r;
    end
  end

  pp_project #(
    .POINT_BITS     (POINT_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_project (
    .clk   (clk),
    .en    (en),
    .fwd   (fwd_a_r),
    .left  (left_a_r),
    .up    (up_a_r),
    .mag_u (mag_u),
    .mag_v (mag_v),
    .mag_w (mag_w),
    .neg_u (neg_u),
    .neg_v (neg_v)
  );

  // Pixels truncate, so the remainder flag of these two is left open.
  pp_div #(.NUM_W(ACC_W), .DEN_W(ACC_W)) u_div_col (
    .clk (clk), .en (en), .num (mag_u), .den (mag_w),
    .quo (qu), .rem_nz (), .ovf (ovf_u)
  );

  pp_div #(.NUM_W(ACC_W), .DEN_W(ACC_W)) u_div_row (
    .clk (clk), .en (en), .num (mag_v), .den (mag_w),
    .quo (qv), .rem_nz (), .ovf (ovf_v)
  );

  pp_div #(.NUM_W(COLOR_NUM_W), .DEN_W(RANGE_W)) u_div_color (
    .clk (clk), .en (en), .num (x_d_r), .den (r_d_r),
    .quo (qc), .rem_nz (rnz_c), .ovf ()
  );

  // Side data alongside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      front_e_r[0] <= front_d_r;
      seg_e_r[0]   <= seg_d_r;
      nu_e_r[0]    <= neg_u;
      nv_e_r[0]    <= neg_v;
      for (int k = 1; k < DIV_LAT; k++) begin
        front_e_r[k] <= front_e_r[k-1];
        seg_e_r[k]   <= seg_e_r[k-1];
        nu_e_r[k]    <= nu_e_r[k-1];
        nv_e_r[k]    <= nv_e_r[k-1];
      end
    end
  end

  pp_color u_color (
    .seg    (seg_e_r[DIV_LAT-1]),
    .quo    (qc),
    .rem_nz (rnz_c),
    .red    (red_c),
    .green  (green_c),
    .blue   (blue_c)
  );

  // Zero divisor always flags overflow, so it never hits.
  assign hit = front_e_r[DIV_LAT-1] && !nu_e_r[DIV_LAT-1] && !nv_e_r[DIV_LAT-1] &&
               !ovf_u && !ovf_v && (qu != '0) && (qu < width_r) &&
               (qv != '0) && (qv < height_r);

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r   <= hit;
      front_r <= front_e_r[DIV_LAT-1];
      col_r   <= hit ? qu : '0;
      row_r   <= hit ? qv : '0;
      red_r   <= front_e_r[DIV_LAT-1] ? red_c   : '0;
      green_r <= front_e_r[DIV_LAT-1] ? green_c : '0;
      blue_r  <= front_e_r[DIV_LAT-1] ? blue_c  : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = hit_r;
  assign out_in_front  = front_r;
  assign out_pixel_col = col_r;
  assign out_pixel_row = row_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;

endmodule

@@ tb/lidar_point_to_pixel_projector_test.sv @@
// Self-checking testbench for the lidar point to pixel projector.
`timescale 1ns / 1ps

module lidar_point_to_pixel_projector_test;
  import pp_pkg::*;

  localparam int PB = POINT_BITS_DEF;

  // Index past the last register; writes to it are dropped.
  localparam logic [IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct {
    logic signed [PB-1:0] fwd;
    logic signed [PB-1:0] left;
    logic signed [PB-1:0] up;
  } point_t;

  typedef struct {
    logic               hit;
    logic               in_front;
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [PB-1:0] in_point_fwd_mm = '0;
  logic signed [PB-1:0] in_point_left_mm = '0;
  logic signed [PB-1:0] in_point_up_mm = '0;
  logic out_valid;
  logic out_ready = 0;
  logic out_hit, out_in_front;
  logic [PIX_W-1:0] out_pixel_col, out_pixel_row;
  logic [COLOR_W-1:0] out_red, out_green, out_blue;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  lidar_point_to_pixel_projector dut (.*);

  initial forever #5 clk = ~clk;

  point_t   pending_points[$];
  pixel_t   expected_pixels[$];
  longint   proj[3][4];
  logic [PIX_W-1:0]   img_w = IMAGE_WIDTH_RST;
  logic [PIX_W-1:0]   img_h = IMAGE_HEIGHT_RST;
  logic [RANGE_W-1:0] crange = COLOR_RANGE_RST;
  int       snd_idle = 0;
  int       rcv_idle = 0;
  int       errors = 0;
  logic     took_item = 0;

  // Round an entry in units of 1e-14 to the coefficient's fraction bits.
  function automatic longint round_coef(longint m);
    longint den, mag, acc, r;
    den = 64'd100000000000000;
    mag = (m < 0) ? -m : m;
    acc = mag / den;
    r = mag % den;
    for (int i = 0; i < COEF_FRAC_BITS_DEF; i++) begin
      acc = acc << 1;
      r = r << 1;
      if (r >= den) begin
        acc = acc | 1;
        r = r - den;
      end
    end
    if (2 * r >= den) acc = acc + 1;
    return (m < 0) ? -acc : acc;
  endfunction

  function automatic void build_projection();
    longint ext[3][4];
    ext = '{'{99994800, -368532, 955344, -3628590},
            '{250985, 99274000, 12025400, -40832200},
            '{-992725, -12022400, 99269700, 4218810}};
    for (int j = 0; j < 4; j++) begin
      proj[0][j] = round_coef(64'd620119409 * ext[0][j] + 64'd329103454 * ext[2][j]);
      proj[1][j] = round_coef(64'd619245417 * ext[1][j] + 64'd248727013 * ext[2][j]);
      proj[2][j] = round_coef(64'd1000000 * ext[2][j]);
    end
  endfunction

  function automatic logic [7:0] clip8(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t  e;
    longint  d[4], acc[3];
    longint  rng, n, fl, cl, mu, mv, mw, qu, qv;
    e = '{0, 0, 0, 0, 0, 0, 0};
    if (p.fwd <= 0) return e;
    e.in_front = 1;
    d[0] = -longint'(p.left);
    d[1] = -longint'(p.up);
    d[2] = longint'(p.fwd);
    d[3] = 1000;
    for (int i = 0; i < 3; i++) begin
      acc[i] = 0;
      for (int j = 0; j < 4; j++) acc[i] += proj[i][j] * d[j];
    end
    if (acc[2] != 0) begin
      mu = (acc[0] < 0) ? -acc[0] : acc[0];
      mv = (acc[1] < 0) ? -acc[1] : acc[1];
      mw = (acc[2] < 0) ? -acc[2] : acc[2];
      qu = mu / mw;
      qv = mv / mw;
      if (((acc[0] < 0) == (acc[2] < 0)) && ((acc[1] < 0) == (acc[2] < 0)) &&
          qu > 0 && qu < img_w && qv > 0 && qv < img_h) begin
        e.hit = 1;
        e.col = qu[PIX_W-1:0];
        e.row = qv[PIX_W-1:0];
      end
    end
    rng = (crange == 0) ? 1 : crange;
    n = 255 * longint'(p.fwd);
    if (n > 255 * rng) n = 255 * rng;
    fl = (4 * n) / rng;
    cl = (4 * n + rng - 1) / rng;
    if (n <= 63 * rng) begin
      e.red = 0; e.green = clip8(fl); e.blue = 255;
    end else if (n <= 127 * rng) begin
      e.red = 0; e.green = 255; e.blue = clip8(511 - cl);
    end else if (n <= 191 * rng) begin
      e.red = clip8(fl - 508); e.green = 255; e.blue = 0;
    end else begin
      e.red = 255; e.green = clip8(1023 - cl); e.blue = 0;
    end
    return e;
  endfunction

  // Driver: hold a presented item until taken, then idle or advance.
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
      if (!in_valid || took_item) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= snd_idle) begin
          in_point_fwd_mm <= pending_points[0].fwd;
          in_point_left_mm <= pending_points[0].left;
          in_point_up_mm <= pending_points[0].up;
          void'(pending_points.pop_front());
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    point_t p;
    pixel_t e;
    took_item <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      p.fwd = in_point_fwd_mm;
      p.left = in_point_left_mm;
      p.up = in_point_up_mm;
      expected_pixels.insert(expected_pixels.size(), project_point(p));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, out_hit); errors++;
        end
        if (out_in_front !== e.in_front) begin
          $error("in_front: expected %0d, got %0d", e.in_front, out_in_front); errors++;
        end
        if (out_pixel_col !== e.col) begin
          $error("pixel_col: expected %0d, got %0d", e.col, out_pixel_col); errors++;
        end
        if (out_pixel_row !== e.row) begin
          $error("pixel_row: expected %0d, got %0d", e.row, out_pixel_row); errors++;
        end
        if (out_red !== e.red) begin
          $error("red: expected %0d, got %0d", e.red, out_red); errors++;
        end
        if (out_green !== e.green) begin
          $error("green: expected %0d, got %0d", e.green, out_green); errors++;
        end
        if (out_blue !== e.blue) begin
          $error("blue: expected %0d, got %0d", e.blue, out_blue); errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == CFG_IMAGE_WIDTH) img_w = val[PIX_W-1:0];
    else if (idx == CFG_IMAGE_HEIGHT) img_h = val[PIX_W-1:0];
    else if (idx == CFG_COLOR_RANGE) crange = val;
  endtask

  task automatic add_point(int f, int l, int u);
    point_t p;
    p.fwd = PB'(f);
    p.left = PB'(l);
    p.up = PB'(u);
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(negedge clk);
    repeat (DIV_LAT + 10) @(negedge clk);
  endtask

  // Mostly points in the camera's view with random depth; the rest is noise.
  task automatic add_random(int count);
    int f, span;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1: add_point($urandom, $urandom, $urandom);
        2: add_point(-$urandom_range(131072), $urandom, $urandom);
        default: begin
          f = $urandom_range(1, 30000);
          span = f / 2 + 1;
          add_point(f, $urandom_range(0, 2 * span) - span,
                    $urandom_range(0, 2 * span) - span);
        end
      endcase
    end
  endtask

  initial begin
    build_projection();
    repeat (5) @(negedge clk);
    rst_n <= 1;

    // Extremes, boundaries of the colour segments, negative W.
    add_point(131071, 0, 0);
    add_point(-131072, 131071, -131072);
    add_point(0, 100, 100);
    add_point(1, 0, 0);
    add_point(5000, 0, 0);
    add_point(5000, 2000, 1500);
    add_point(5000, -2000, -1500);
    add_point(2470, 0, 0);
    add_point(2471, 0, 0);
    add_point(4980, 0, 0);
    add_point(4981, 0, 0);
    add_point(7490, 0, 0);
    add_point(7491, 0, 0);
    add_point(10000, 0, 0);
    add_point(20000, 131071, 131071);
    add_point(1, 0, -131072);
    add_point(1, 131071, -131072);
    add_point(131071, -131072, 131071);
    add_point(-1, -1, -1);
    add_point(3, -131072, -131072);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      snd_idle = (ph < 2) ? 34 : (ph < 4) ? 88 : 0;
      rcv_idle = (ph < 2) ? 88 : (ph < 4) ? 34 : 0;
      case (ph)
        0: begin
          write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
          write_reg(CFG_IMAGE_HEIGHT, 4095);
          write_reg(CFG_COLOR_RANGE, 65535);
        end
        1: begin
          write_reg(CFG_IMAGE_WIDTH, 1);
          write_reg(CFG_IMAGE_HEIGHT, 1);
          write_reg(CFG_COLOR_RANGE, 1);
        end
        2: begin
          write_reg(CFG_IMAGE_WIDTH, 16'h1000);
          write_reg(CFG_IMAGE_HEIGHT, 300);
          write_reg(CFG_COLOR_RANGE, 0);
        end
        3: begin
          write_reg(CFG_IMAGE_WIDTH, 640);
          write_reg(CFG_IMAGE_HEIGHT, 16'hF000);
          write_reg(CFG_COLOR_RANGE, 5000);
          write_reg(CFG_SPARE_IDX, 16'hFFFF);
        end
        4: begin
          write_reg(CFG_IMAGE_WIDTH, CFG_W'($urandom));
          write_reg(CFG_IMAGE_HEIGHT, CFG_W'($urandom));
          write_reg(CFG_COLOR_RANGE, CFG_W'($urandom));
        end
        default: begin
          write_reg(CFG_IMAGE_WIDTH, 640);
          write_reg(CFG_IMAGE_HEIGHT, 480);
          write_reg(CFG_COLOR_RANGE, 10000);
        end
      endcase
      add_random(100);
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
